@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define GCB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define GCB_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ src/gcb_pkg.sv @@
// shared types, constants and elaboration-time table functions
package gcb_pkg;

    typedef struct packed {
        logic zero;
        logic full;
    } gcb_tag_t;

    localparam int unsigned GAMMA_MIN   = 80;
    localparam int unsigned GAMMA_MAX   = 260;
    localparam int          PCT_LIMIT   = 50;
    localparam int unsigned PCT_SCALE   = 100;
    localparam int unsigned FULL_SCALE  = 255;
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [1:0] REG_GAMMA    = 2'd0;
    localparam logic [1:0] REG_BRIGHT   = 2'd1;
    localparam logic [1:0] REG_CONTRAST = 2'd2;

    function automatic longint unsigned isqrt_u64(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned rem;
        res  = 0;
        rem  = x;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2 of x (1..255) with f fraction bits
    function automatic longint log2_fix(input int unsigned x, input int unsigned f);
        int              k;
        longint unsigned z;
        longint          res;
        k = 7;
        while (k > 0 && ((x >> k) & 1) == 0)
            k = k - 1;
        z   = (longint'(x) << f) >> k;
        res = longint'(k) << f;
        for (int i = 1; i <= int'(f); i++)
        begin
            z = (z * z) >> f;
            if (z >= (64'd2 << f))
            begin
                z   = z >> 1;
                res = res + (longint'(1) << (int'(f) - i));
            end
        end
        return res;
    endfunction

    // 2^(-2^-i) with f fraction bits, by repeated square roots
    function automatic longint unsigned exp_root(input int unsigned i, input int unsigned f);
        longint unsigned s;
        s = isqrt_u64(64'd1 << (2 * f - 1));
        for (int j = 1; j < int'(i); j++)
            s = isqrt_u64(s << f);
        return s;
    endfunction

endpackage

@@ src/pixel_gamma_contrast_brightness.sv @@
// top level: gamma, contrast and brightness correction of one channel value
// Takes one 8-bit channel value per clock while in_ready is high and returns it
// corrected, one beat out per beat in. Pipeline: one table stage for the log,
// FRACTION_BITS+4 divider stages for the exponent divide by gamma,
// FRACTION_BITS root-multiply stages plus one shift stage for the power, then two
// stages for contrast, brightness and scaling, and the output register. A two-entry
// output buffer keeps input ready registered; it drops only while a result waits
// in the buffer. Registers: 0 gamma_percent, 1 brightness_percent,
// 2 contrast_percent, each saturated to its range when used; write them idle.
`include "assert_macros.svh"
module pixel_gamma_contrast_brightness #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  channel_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  adjusted_value
);
    import gcb_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int MW = F + 3;
    localparam int NW = MW + 7;
    localparam int QW = F + 4;
    localparam int YW = F + 10;
    localparam int TW = F + 15;

    logic [8:0]        gamma_reg;
    logic [6:0]        bright_reg;
    logic [6:0]        contrast_reg;
    logic [8:0]        g_c;
    logic signed [7:0] b_c;
    logic signed [7:0] c_c;

    logic              en;
    logic [MW-1:0]     m_tab [256];
    logic              a_valid_reg;
    logic [MW-1:0]     a_m_reg;
    gcb_tag_t          a_tag_reg;
    logic [NW-1:0]     num;

    logic              d_valid;
    logic [QW-1:0]     d_quot;
    gcb_tag_t          d_tag;
    logic              e_valid;
    logic [F:0]        e_pow;

    logic              y_valid_reg;
    logic signed [YW-1:0] y_reg;
    logic signed [YW-1:0] y_calc;
    logic [YW-1:0]     y_clamped;
    logic [TW-1:0]     t_full;
    logic              t_valid_reg;
    logic [14:0]       t_reg;
    logic [27:0]       q_prod;
    logic [7:0]        q_value;

    logic              out_valid_reg;
    logic [7:0]        out_value_reg;
    logic              skid_valid_reg;
    logic [7:0]        skid_value_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg    <= 9'd100;
            bright_reg   <= '0;
            contrast_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAMMA:    gamma_reg    <= cfg_data;
                REG_BRIGHT:   bright_reg   <= cfg_data[6:0];
                REG_CONTRAST: contrast_reg <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        if (gamma_reg < 9'(GAMMA_MIN))
            g_c = 9'(GAMMA_MIN);
        else if (gamma_reg > 9'(GAMMA_MAX))
            g_c = 9'(GAMMA_MAX);
        else
            g_c = gamma_reg;

        b_c = 8'(signed'(bright_reg));
        if (b_c < 8'sd0 - 8'(PCT_LIMIT))
            b_c = 8'sd0 - 8'(PCT_LIMIT);
        else if (b_c > 8'(PCT_LIMIT))
            b_c = 8'(PCT_LIMIT);

        c_c = 8'(signed'(contrast_reg));
        if (c_c < 8'sd0 - 8'(PCT_LIMIT))
            c_c = 8'sd0 - 8'(PCT_LIMIT);
        else if (c_c > 8'(PCT_LIMIT))
            c_c = 8'(PCT_LIMIT);
    end

    // pipeline advances while the output buffer has room
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // log magnitude table: log2(255) - log2(x)
    for (genvar gx = 0; gx < 256; gx++)
    begin : g_log
        localparam longint LM = (gx == 0 || gx == 255) ? 0 :
                                log2_fix(255, F) - log2_fix(gx, F);
        assign m_tab[gx] = (LM < 0) ? '0 : MW'(LM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_m_reg        <= m_tab[channel_value];
            a_tag_reg.zero <= channel_value == 8'd0;
            a_tag_reg.full <= channel_value == 8'(FULL_SCALE);
        end
    end

    assign num = NW'(a_m_reg) * NW'(PCT_SCALE);

    gcb_div #(
        .NW (NW),
        .QW (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_num    (num),
        .in_tag    (a_tag_reg),
        .divisor   (g_c),
        .out_valid (d_valid),
        .out_quot  (d_quot),
        .out_tag   (d_tag)
    );

    gcb_exp2 #(
        .F (F)
    ) u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_exp    (d_quot),
        .in_tag    (d_tag),
        .out_valid (e_valid),
        .out_pow   (e_pow)
    );

    // contrast about mid-grey plus brightness, in hundredths
    assign y_calc = (signed'(YW'(e_pow)) - signed'(YW'(1) << (F - 1)))
                    * (signed'(YW'(c_c)) + signed'(YW'(PCT_SCALE)))
                    + signed'(YW'(PCT_SCALE) << (F - 1))
                    + (signed'(YW'(b_c)) <<< F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            y_valid_reg <= e_valid;
            t_valid_reg <= y_valid_reg;
        end
    end

    always_comb
    begin
        if (y_reg < 0)
            y_clamped = '0;
        else if (y_reg > signed'(YW'(PCT_SCALE) << F))
            y_clamped = YW'(PCT_SCALE) << F;
        else
            y_clamped = unsigned'(y_reg);
        t_full = TW'(y_clamped) * TW'(FULL_SCALE) + (TW'(PCT_LIMIT) << F);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_calc;
            t_reg <= t_full[F+14:F];
        end
    end

    // divide by one hundred through the reciprocal
    assign q_prod  = 28'(t_reg) * 28'(RECIP_100);
    assign q_value = q_prod[RECIP_SHIFT+7:RECIP_SHIFT];

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!en)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (t_valid_reg)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en)
        begin
            if (out_ready)
                out_value_reg <= skid_value_reg;
        end
        else if (t_valid_reg)
        begin
            if (!out_valid_reg || out_ready)
                out_value_reg <= q_value;
            else
                skid_value_reg <= q_value;
        end
    end

    assign out_valid      = out_valid_reg;
    assign adjusted_value = out_value_reg;

    `GCB_NEVER(a_skid_without_out, skid_valid_reg && !out_valid_reg)
    `GCB_ASSERT(a_skid_holds, skid_valid_reg && !out_ready |=> skid_valid_reg)
    `GCB_ASSERT(a_skid_fills, en && t_valid_reg && out_valid_reg && !out_ready |=> skid_valid_reg)

endmodule

@@ src/gcb_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module gcb_div #(
    parameter int NW = 26,
    parameter int QW = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [NW-1:0]           in_num,
    input  gcb_pkg::gcb_tag_t       in_tag,
    input  logic [8:0]              divisor,
    output logic                    out_valid,
    output logic [QW-1:0]           out_quot,
    output gcb_pkg::gcb_tag_t       out_tag
);
    import gcb_pkg::*;

    logic              v_reg   [QW+1];
    logic [8:0]        rem_reg [QW+1];
    logic [QW-1:0]     low_reg [QW+1];
    logic [QW-1:0]     q_reg   [QW+1];
    gcb_tag_t          tag_reg [QW+1];

    assign v_reg[0]   = in_valid;
    assign rem_reg[0] = 9'(in_num[NW-1:QW]);
    assign low_reg[0] = in_num[QW-1:0];
    assign q_reg[0]   = '0;
    assign tag_reg[0] = in_tag;

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic [9:0] trial;
        logic       ge;
        assign trial = {rem_reg[j], low_reg[j][QW-1]};
        assign ge    = trial >= {1'b0, divisor};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (en)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? 9'(trial - {1'b0, divisor}) : trial[8:0];
                low_reg[j+1] <= {low_reg[j][QW-2:0], 1'b0};
                q_reg[j+1]   <= {q_reg[j][QW-2:0], ge};
                tag_reg[j+1] <= tag_reg[j];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_quot  = q_reg[QW];
    assign out_tag   = tag_reg[QW];

endmodule

@@ src/gcb_exp2.sv @@
// pipelined 2^(-e), one conditional root multiply per root stage, then a shift stage
module gcb_exp2 #(
    parameter int F = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [F+3:0]            in_exp,
    input  gcb_pkg::gcb_tag_t       in_tag,
    output logic                    out_valid,
    output logic [F:0]              out_pow
);
    import gcb_pkg::*;

    logic          v_reg   [F+1];
    logic [F:0]    r_reg   [F+1];
    logic [F-1:0]  fr_reg  [F+1];
    logic [3:0]    ip_reg  [F+1];
    gcb_tag_t      tag_reg [F+1];
    logic          out_valid_reg;
    logic [F:0]    out_pow_reg;
    logic [F:0]    shifted;

    assign v_reg[0]   = in_valid;
    assign r_reg[0]   = (F+1)'(1) << F;
    assign fr_reg[0]  = in_exp[F-1:0];
    assign ip_reg[0]  = in_exp[F+3:F];
    assign tag_reg[0] = in_tag;

    for (genvar i = 1; i <= F; i++)
    begin : g_stage
        localparam longint unsigned SV = exp_root(i, F);
        localparam logic [F-1:0] S = F'(SV);
        logic [2*F:0] prod;
        assign prod = r_reg[i-1] * S;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]   <= fr_reg[i-1][F-i] ? prod[2*F:F] : r_reg[i-1];
                fr_reg[i]  <= fr_reg[i-1];
                ip_reg[i]  <= ip_reg[i-1];
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign shifted = (32'(ip_reg[F]) > F) ? '0 : (r_reg[F] >> ip_reg[F]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_reg[F];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (tag_reg[F].zero)
                out_pow_reg <= '0;
            else if (tag_reg[F].full)
                out_pow_reg <= (F+1)'(1) << F;
            else
                out_pow_reg <= shifted;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pow   = out_pow_reg;

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the gamma, contrast and brightness pixel correction block
`timescale 1ns / 1ps
module tb_top;
    import gcb_pkg::*;

    localparam int FB = 16;
    localparam int PIPE_LAT = 2 * FB + 9;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] channel_value;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] adjusted_value;

    pixel_gamma_contrast_brightness #(.FRACTION_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .channel_value(channel_value),
        .out_valid(out_valid), .out_ready(out_ready), .adjusted_value(adjusted_value)
    );

    logic [8:0] gamma_reg;
    logic [6:0] bright_reg;
    logic [6:0] contrast_reg;

    logic [7:0] pixel_q[$];
    logic [7:0] corrected_q[$];
    bit         errors;
    bit         send_idle_en;
    bit         recv_idle_en;
    bit         hold_recv;
    int         send_gap;
    int         recv_gap;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned sqrt_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned bv;
        r = 0;
        bv = 64'd1 << 62;
        while (bv > x)
            bv = bv >> 2;
        while (bv != 0)
        begin
            if (x >= r + bv)
            begin
                x = x - (r + bv);
                r = (r >> 1) + bv;
            end
            else
                r = r >> 1;
            bv = bv >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_q(input int x);
        int k;
        longint unsigned z;
        longint res;
        k = 7;
        while (k > 0 && ((x >> k) & 1) == 0)
            k--;
        z = (longint'(x) << FB) >> k;
        res = longint'(k) << FB;
        for (int i = 1; i <= FB; i++)
        begin
            z = (z * z) >> FB;
            if (z >= (64'd2 << FB))
            begin
                z = z >> 1;
                res = res + (longint'(1) << (FB - i));
            end
        end
        return res;
    endfunction

    function automatic longint pow2_neg(input longint unsigned e);
        longint unsigned r;
        longint unsigned s;
        longint unsigned ip;
        r = 64'd1 << FB;
        s = sqrt_floor(64'd1 << (2 * FB - 1));
        ip = e >> FB;
        for (int i = 1; i <= FB; i++)
        begin
            if ((e >> (FB - i)) & 1)
                r = (r * s) >> FB;
            s = sqrt_floor(s << FB);
        end
        if (ip > FB)
            return 0;
        return longint'(r >> ip);
    endfunction

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [7:0] correct_pixel(input logic [7:0] x);
        longint g;
        longint b;
        longint c;
        longint p;
        longint m;
        longint y;
        longint one;
        g = sat(longint'(gamma_reg), GAMMA_MIN, GAMMA_MAX);
        b = sat(longint'($signed(bright_reg)), -PCT_LIMIT, PCT_LIMIT);
        c = sat(longint'($signed(contrast_reg)), -PCT_LIMIT, PCT_LIMIT);
        one = longint'(1) << FB;
        if (x == 0)
            p = 0;
        else if (x == 255)
            p = one;
        else
        begin
            m = log2_q(255) - log2_q(x);
            if (m < 0)
                m = 0;
            p = pow2_neg((m * 100) / g);
        end
        y = (p - one / 2) * (100 + c) + (one / 2) * 100 + b * one;
        y = sat(y, 0, 100 * one);
        return 8'((y * 255 + 50 * one) / (100 * one));
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAMMA:    gamma_reg    = val;
            REG_BRIGHT:   bright_reg   = val[6:0];
            REG_CONTRAST: contrast_reg = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [8:0] g, input logic [6:0] b, input logic [6:0] c);
        write_reg(REG_GAMMA, g);
        write_reg(REG_BRIGHT, {2'b00, b});
        write_reg(REG_CONTRAST, {2'b00, c});
    endtask

    task automatic drain;
        while (pixel_q.size() != 0 || corrected_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            channel_value <= 8'd0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                corrected_q.push_back(correct_pixel(channel_value));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (send_idle_en && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 17) - 1;
                    in_valid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    channel_value <= pixel_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (corrected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, actual %0d", $time, adjusted_value);
                    errors = 1'b1;
                end
                else
                begin
                    logic [7:0] want;
                    want = corrected_q.pop_front();
                    if (want !== adjusted_value)
                    begin
                        $display("%0t: adjusted_value expected %0d actual %0d",
                                 $time, want, adjusted_value);
                        errors = 1'b1;
                    end
                end
            end
            if (hold_recv)
                out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (recv_idle_en && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 2'd0;
        cfg_data = 9'd0;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        hold_recv = 1'b0;
        gamma_reg = 9'd100;
        bright_reg = 7'd0;
        contrast_reg = 7'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset settings, then extremes and saturation
        pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd255);
        pixel_q.push_back(8'd1);
        pixel_q.push_back(8'd128);
        pixel_q.push_back(8'd127);
        pixel_q.push_back(8'd254);
        pixel_q.push_back(8'h55);
        pixel_q.push_back(8'hAA);
        drain();
        set_all(9'd80, 7'd50, 7'h4E);
        pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd255);
        pixel_q.push_back(8'd1);
        pixel_q.push_back(8'd200);
        drain();
        set_all(9'd511, 7'h40, 7'd63);
        pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd255);
        pixel_q.push_back(8'd1);
        pixel_q.push_back(8'd64);
        drain();
        set_all(9'd0, 7'h3F, 7'h41);
        pixel_q.push_back(8'd2);
        pixel_q.push_back(8'd100);
        pixel_q.push_back(8'd254);
        drain();
        write_reg(2'd3, 9'h1FF);
        set_all(9'd260, 7'h4E, 7'd50);
        pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd255);
        pixel_q.push_back(8'd3);
        drain();

        // random phases
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_all(9'($urandom_range(0, 511)), 7'($urandom), 7'($urandom));
            if (ph == 2)
            begin
                hold_recv = 1'b1;
                send_idle_en = 1'b0;
            end
            for (int n = 0; n < 130; n++)
                pixel_q.push_back(8'($urandom));
            if (ph == 2)
            begin
                repeat (300) @(posedge clk);
                hold_recv = 1'b0;
                send_idle_en = 1'b1;
            end
            drain();
        end
        // last part without idling
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        set_all(9'($urandom_range(80, 260)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
        for (int n = 0; n < 100; n++)
            pixel_q.push_back(8'($urandom));
        drain();

        if (!errors)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
